@@ rtl/ws2812_pixel_pulse_encoder_defines.svh @@
// assertion macros shared by the pixel pulse encoder rtl
// no dependencies; included by modules that carry assertions
`ifndef WS2812_PIXEL_PULSE_ENCODER_DEFINES_SVH
`define WS2812_PIXEL_PULSE_ENCODER_DEFINES_SVH

// same-cycle implication
`define WPPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WPPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wppe_pkg.sv @@
// shared types, constants and helpers of the pixel pulse encoder
// no dependencies
`timescale 1ns / 1ps

package wppe_pkg;

	localparam int COLOR_W        = 24;
	localparam int CHAN_W         = 8;
	localparam int TICK_W         = 15;
	localparam int CFG_IDX_W      = 3;
	localparam int BITS_PER_PIXEL = 24;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [CHAN_W-1:0] BRIGHTNESS_RST = 8'd50;
	localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 15'd14;
	localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 15'd36;
	localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 15'd28;
	localparam logic [TICK_W-1:0] ONE_LOW_RST    = 15'd22;
	localparam logic [TICK_W-1:0] LATCH_RST      = 15'd11200;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRIGHTNESS = 3'd0,
		CFG_ZERO_HIGH  = 3'd1,
		CFG_ZERO_LOW   = 3'd2,
		CFG_ONE_HIGH   = 3'd3,
		CFG_ONE_LOW    = 3'd4,
		CFG_LATCH      = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		ST_BITS  = 1'b0,
		ST_LATCH = 1'b1
	} sym_state_t;

	// one scaled pixel as queued between front and back
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               last;
	} pix_t;

	// timing registers seen by the symbol sequencer
	typedef struct packed {
		logic [TICK_W-1:0] zero_high;
		logic [TICK_W-1:0] zero_low;
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] one_low;
		logic [TICK_W-1:0] latch;
	} timing_t;

	// exact floor(x / 255) for x up to 255 * 255
	function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
		logic [2*CHAN_W:0] sum;
		sum = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
		return sum[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

@@ rtl/wppe_front.sv @@
// front end: accepts pixels and scales each channel by brightness
// depends on wppe_pkg
`timescale 1ns / 1ps

module wppe_front import wppe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COLOR_W-1:0] pixel_color,
	input  logic               last_pixel,
	input  logic [CHAN_W-1:0]  brightness,
	output logic               push,
	output pix_t               push_data,
	input  logic               queue_full
);

	logic                  valid_s1;
	logic [2*CHAN_W-1:0]   prod_g_s1;
	logic [2*CHAN_W-1:0]   prod_r_s1;
	logic [2*CHAN_W-1:0]   prod_b_s1;
	logic                  last_s1;
	logic                  valid_s2;
	pix_t                  pix_s2;
	logic                  adv_s2;
	logic                  adv_s1;

	assign push     = valid_s2 && !queue_full;
	assign adv_s2   = !valid_s2 || !queue_full;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// channel products
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			prod_g_s1 <= pixel_color[23:16] * brightness;
			prod_r_s1 <= pixel_color[15:8] * brightness;
			prod_b_s1 <= pixel_color[7:0] * brightness;
			last_s1   <= last_pixel;
		end
	end

	// divide by full scale
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pix_s2.color <= {div255(prod_g_s1), div255(prod_r_s1), div255(prod_b_s1)};
			pix_s2.last  <= last_s1;
		end
	end

	assign push_data = pix_s2;

endmodule

@@ rtl/wppe_queue.sv @@
// small register queue between front end and symbol sequencer
// depends on wppe_pkg
`timescale 1ns / 1ps

module wppe_queue import wppe_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pix_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output pix_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pix_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/wppe_back.sv @@
// back end: turns the queued pixel into pulse symbols, one per cycle while the receiver does not stall
// depends on wppe_pkg and ws2812_pixel_pulse_encoder_defines.svh
`timescale 1ns / 1ps
`include "ws2812_pixel_pulse_encoder_defines.svh"

module wppe_back import wppe_pkg::*; #(
	parameter int BITS = BITS_PER_PIXEL
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  pix_t              head,
	output logic              pop,
	input  timing_t           timing,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              first_level,
	output logic [TICK_W-1:0] first_ticks,
	output logic [TICK_W-1:0] second_ticks,
	output logic              last_symbol
);

	localparam int IDX_W = $clog2(BITS);

	sym_state_t        state_q;
	sym_state_t        state_nxt;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_nxt;
	logic [BITS-1:0]   word;
	logic              fire;
	logic              sym_level;
	logic [TICK_W-1:0] sym_t1;
	logic [TICK_W-1:0] sym_t2;
	logic              sym_last;
	logic              out_valid_q;
	logic              level_q;
	logic [TICK_W-1:0] t1_q;
	logic [TICK_W-1:0] t2_q;
	logic              last_q;

	// leading bits beyond the colour word go out as zeros
	assign word = BITS'(head.color);
	assign fire = head_valid && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_nxt = state_q;
		idx_nxt   = idx_q;
		pop       = 1'b0;
		unique case (state_q)
			ST_BITS: begin
				if (fire) begin
					if (idx_q == '0) begin
						idx_nxt = IDX_W'(BITS - 1);
						if (head.last)
							state_nxt = ST_LATCH;
						else
							pop = 1'b1;
					end else begin
						idx_nxt = idx_q - 1'b1;
					end
				end
			end
			ST_LATCH: begin
				if (fire) begin
					state_nxt = ST_BITS;
					pop       = 1'b1;
				end
			end
			default: state_nxt = ST_BITS;
		endcase
	end

	// symbol fields
	always_comb begin
		sym_level = 1'b1;
		sym_t1    = timing.zero_high;
		sym_t2    = timing.zero_low;
		sym_last  = 1'b0;
		unique case (state_q)
			ST_BITS: begin
				if (word[idx_q]) begin
					sym_t1 = timing.one_high;
					sym_t2 = timing.one_low;
				end
				sym_last = (idx_q == '0) && !head.last;
			end
			ST_LATCH: begin
				sym_level = 1'b0;
				sym_t1    = timing.latch;
				sym_t2    = '0;
				sym_last  = 1'b1;
			end
			default: sym_level = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BITS;
			idx_q       <= IDX_W'(BITS - 1);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			idx_q       <= idx_nxt;
			out_valid_q <= fire || (out_valid_q && out_stall);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire) begin
			level_q <= sym_level;
			t1_q    <= sym_t1;
			t2_q    <= sym_t2;
			last_q  <= sym_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign first_level  = level_q;
	assign first_ticks  = t1_q;
	assign second_ticks = t2_q;
	assign last_symbol  = last_q;

	`WPPE_ASSERT_IMP(a_latch_needs_last, clk, arst_n, state_q == ST_LATCH,
		head_valid && head.last, "latch symbol without a last pixel at queue head")
	`WPPE_ASSERT_IMP(a_pop_on_final, clk, arst_n, pop,
		fire && (state_q == ST_LATCH || (idx_q == '0 && !head.last)),
		"pixel dropped before its final symbol")
	`WPPE_ASSERT_NXT(a_idx_counts_down, clk, arst_n,
		fire && state_q == ST_BITS && idx_q != '0,
		idx_q == $past(idx_q) - 1'b1, "bit index skipped")

endmodule

@@ rtl/ws2812_pixel_pulse_encoder.sv @@
// top level of the pixel pulse encoder: configuration registers and block wiring
// depends on wppe_pkg, wppe_front, wppe_queue, wppe_back
//
// usage
//   input channel (in_valid / in_stall): one packed grb pixel per request with
//   last_pixel marking the end of a frame. output channel (out_valid / out_stall):
//   one pulse symbol per request, a high phase then a low phase, or the low latch
//   symbol that follows the last pixel of a frame.
//   config channel (cfg_valid / cfg_ready, always ready): register index and data;
//   the user must write them only while the block is idle, which the block does
//   not enforce; unknown indexes are ignored. a taken pixel passes both scaling
//   stages, the queue write and the output register before its first symbol is out.
//   the symbol sequencer sends one symbol per cycle while the receiver does not
//   stall: BITS_PER_PIXEL data symbols per pixel, plus the latch symbol of a last pixel.
//   a short queue of up to QUEUE_DEPTH pixels lets the scaling front end run ahead.
//   reset clears the pipeline and queue and loads the default brightness and timing registers.
//   when the receiver stalls, the held symbol stays put, the queue fills and
//   in_stall rises once the queue and both scaling stages are full.
`timescale 1ns / 1ps

module ws2812_pixel_pulse_encoder import wppe_pkg::*; #(
	parameter int BITS_PER_PIXEL = wppe_pkg::BITS_PER_PIXEL,
	parameter int QUEUE_DEPTH    = wppe_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COLOR_W-1:0]   pixel_color,
	input  logic                 last_pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 first_level,
	output logic [TICK_W-1:0]    first_ticks,
	output logic [TICK_W-1:0]    second_ticks,
	output logic                 last_symbol,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	logic [CHAN_W-1:0] brightness_q;
	timing_t           timing_q;
	logic              push;
	pix_t              push_data;
	logic              queue_full;
	logic              pop;
	logic              head_valid;
	pix_t              head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q       <= BRIGHTNESS_RST;
			timing_q.zero_high <= ZERO_HIGH_RST;
			timing_q.zero_low  <= ZERO_LOW_RST;
			timing_q.one_high  <= ONE_HIGH_RST;
			timing_q.one_low   <= ONE_LOW_RST;
			timing_q.latch     <= LATCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BRIGHTNESS: brightness_q       <= cfg_data[CHAN_W-1:0];
				CFG_ZERO_HIGH:  timing_q.zero_high <= cfg_data;
				CFG_ZERO_LOW:   timing_q.zero_low  <= cfg_data;
				CFG_ONE_HIGH:   timing_q.one_high  <= cfg_data;
				CFG_ONE_LOW:    timing_q.one_low   <= cfg_data;
				CFG_LATCH:      timing_q.latch     <= cfg_data;
				default:        brightness_q       <= brightness_q;
			endcase
		end
	end

	wppe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel),
		.brightness  (brightness_q),
		.push        (push),
		.push_data   (push_data),
		.queue_full  (queue_full)
	);

	wppe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	wppe_back #(
		.BITS (BITS_PER_PIXEL)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.timing       (timing_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_level  (first_level),
		.first_ticks  (first_ticks),
		.second_ticks (second_ticks),
		.last_symbol  (last_symbol)
	);

endmodule

@@ sim/ws2812_pixel_pulse_encoder_tb.sv @@
// self-checking bench for ws2812_pixel_pulse_encoder: pixels and register writes in, pulse symbols out
// predicts every symbol from each taken pixel and the register copy; depends on wppe_pkg and the rtl
`timescale 1ns / 1ps

module ws2812_pixel_pulse_encoder_tb;
	import wppe_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;
	localparam logic [TICK_W-1:0]    TICK_MAX     = 15'h7FFF;

	typedef struct packed {
		logic              level;
		logic [TICK_W-1:0] first;
		logic [TICK_W-1:0] second;
		logic              last;
	} pulse_t;

	class pulse_scoreboard;
		logic [CHAN_W-1:0] brightness;
		logic [TICK_W-1:0] zero_high, zero_low, one_high, one_low, latch_len;
		pulse_t            pending_pulses[$];
		int unsigned       mismatches;

		function new();
			brightness = BRIGHTNESS_RST;
			zero_high  = ZERO_HIGH_RST;
			zero_low   = ZERO_LOW_RST;
			one_high   = ONE_HIGH_RST;
			one_low    = ONE_LOW_RST;
			latch_len  = LATCH_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
			case (idx)
				CFG_BRIGHTNESS: brightness = data[CHAN_W-1:0];
				CFG_ZERO_HIGH:  zero_high  = data;
				CFG_ZERO_LOW:   zero_low   = data;
				CFG_ONE_HIGH:   one_high   = data;
				CFG_ONE_LOW:    one_low    = data;
				CFG_LATCH:      latch_len  = data;
				default: ;
			endcase
		endfunction

		function logic [CHAN_W-1:0] scale(logic [CHAN_W-1:0] c);
			int unsigned prod;
			prod = int'(c) * int'(brightness);
			return CHAN_W'(prod / 255);
		endfunction

		// expands one taken pixel into its data symbols and, for a last pixel, the latch
		function void predict_pixel(logic [COLOR_W-1:0] color, logic last);
			logic [COLOR_W-1:0] scaled;
			logic               b;
			pulse_t             p;
			scaled = {scale(color[23:16]), scale(color[15:8]), scale(color[7:0])};
			for (int i = BITS_PER_PIXEL - 1; i >= 0; i--) begin
				b = (i < COLOR_W) ? scaled[i] : 1'b0;
				p.level  = 1'b1;
				p.first  = b ? one_high : zero_high;
				p.second = b ? one_low : zero_low;
				p.last   = (i == 0) && !last;
				pending_pulses.push_back(p);
			end
			if (last) begin
				p.level  = 1'b0;
				p.first  = latch_len;
				p.second = '0;
				p.last   = 1'b1;
				pending_pulses.push_back(p);
			end
		endfunction

		function void check_pulse(pulse_t got);
			pulse_t exp;
			if (pending_pulses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected symbol: level %0d first %0d second %0d last %0d",
						got.level, got.first, got.second, got.last);
				return;
			end
			exp = pending_pulses.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("symbol mismatch at %0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
						$realtime, exp.level, exp.first, exp.second, exp.last,
						got.level, got.first, got.second, got.last);
			end
		endfunction

		function int pending();
			return pending_pulses.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [COLOR_W-1:0]   pixel_color;
	logic                 last_pixel;
	logic                 out_valid;
	logic                 out_stall;
	logic                 first_level;
	logic [TICK_W-1:0]    first_ticks;
	logic [TICK_W-1:0]    second_ticks;
	logic                 last_symbol;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	pulse_scoreboard sb = new();

	int   max_burst, max_gap, burst_left;
	int   rx_mode, rx_run, rx_left;
	logic rx_level;
	logic hold_req, hold_done;

	ws2812_pixel_pulse_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_color(pixel_color),
		.last_pixel(last_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.first_level(first_level),
		.first_ticks(first_ticks),
		.second_ticks(second_ticks),
		.last_symbol(last_symbol),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.predict_pixel(pixel_color, last_pixel);
			if (out_valid && !out_stall)
				sb.check_pulse({first_level, first_ticks, second_ticks, last_symbol});
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// receiver: random runs of stall, plus one long hold-off on request
	initial begin
		rx_run    = 0;
		rx_left   = 0;
		rx_level  = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				rx_left   = 300;
			end
			if (rx_left > 0) begin
				rx_left--;
				out_stall <= 1'b1;
			end else begin
				if (rx_run == 0) begin
					rx_run = $urandom_range(1, 12);
					case (rx_mode)
						0:       rx_level = 1'b0;
						1:       rx_level = ($urandom_range(0, 99) < 30);
						default: rx_level = ($urandom_range(0, 99) < 70);
					endcase
				end
				rx_run--;
				out_stall <= rx_level;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input logic [COLOR_W-1:0] color, input logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, max_burst);
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		pixel_color <= color;
		last_pixel  <= last;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering pixels, then wait until every symbol has come out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [TICK_W-1:0] pick_ticks();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 15'd1;
			2:       return TICK_MAX;
			default: return TICK_W'($urandom_range(0, 32767));
		endcase
	endfunction

	task automatic shuffle_regs();
		case ($urandom_range(0, 4))
			0:       write_reg(CFG_BRIGHTNESS, 15'd0);
			1:       write_reg(CFG_BRIGHTNESS, 15'd255);
			2:       write_reg(CFG_BRIGHTNESS, TICK_W'($urandom_range(0, 32767)));
			default: write_reg(CFG_BRIGHTNESS, TICK_W'($urandom_range(0, 255)));
		endcase
		write_reg(CFG_ZERO_HIGH, pick_ticks());
		write_reg(CFG_ZERO_LOW, pick_ticks());
		write_reg(CFG_ONE_HIGH, pick_ticks());
		write_reg(CFG_ONE_LOW, pick_ticks());
		write_reg(CFG_LATCH, pick_ticks());
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
				TICK_W'($urandom_range(0, 32767)));
	endtask

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 24'hFFFFFF;
			default: return COLOR_W'($urandom());
		endcase
	endfunction

	// mostly whole frames ending in a last pixel, some loose pixels with a random flag
	task automatic random_phase(input int n_items);
		int count, frame;
		count = 0;
		while (count < n_items) begin
			if ($urandom_range(0, 99) < 80) begin
				frame = $urandom_range(1, 6);
				for (int k = 0; k < frame; k++)
					push_pixel(pick_color(), k == frame - 1);
				count += frame;
			end else begin
				push_pixel(pick_color(), 1'($urandom_range(0, 1)));
				count++;
			end
		end
		settle();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		pixel_color = '0;
		last_pixel  = 1'b0;
		out_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_BRIGHTNESS;
		cfg_data    = '0;
		hold_req    = 1'b0;
		rx_mode     = 0;
		max_burst   = 1000;
		max_gap     = 0;
		burst_left  = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset timing, no idling at either end
		push_pixel(24'hFFFFFF, 1'b0);
		push_pixel(24'h000000, 1'b1);
		push_pixel(24'h123456, 1'b1);
		push_pixel(24'hFF00FF, 1'b0);
		settle();

		// full brightness, longest phases
		write_reg(CFG_BRIGHTNESS, 15'd255);
		write_reg(CFG_ZERO_HIGH, TICK_MAX);
		write_reg(CFG_ZERO_LOW, TICK_MAX);
		write_reg(CFG_ONE_HIGH, TICK_MAX);
		write_reg(CFG_ONE_LOW, TICK_MAX);
		write_reg(CFG_LATCH, TICK_MAX);
		rx_mode    = 1;
		max_burst  = 3;
		max_gap    = 4;
		burst_left = 0;
		push_pixel(24'hFFFFFF, 1'b0);
		push_pixel(24'h000000, 1'b0);
		push_pixel(24'hA5C35A, 1'b1);
		push_pixel(24'h800001, 1'b0);
		push_pixel(24'h7F7F7F, 1'b1);
		settle();

		// zero-length phases and latch, brightness cut to zero by a wide value
		write_reg(CFG_BRIGHTNESS, 15'h7F00);
		write_reg(CFG_ZERO_HIGH, 15'd0);
		write_reg(CFG_ZERO_LOW, 15'd0);
		write_reg(CFG_ONE_HIGH, 15'd0);
		write_reg(CFG_ONE_LOW, 15'd0);
		write_reg(CFG_LATCH, 15'd0);
		rx_mode = 2;
		push_pixel(24'hFFFFFF, 1'b1);
		push_pixel(24'h5A5A5A, 1'b0);
		settle();

		// wide value giving full scale, writes to unused indexes must be ignored
		write_reg(CFG_BRIGHTNESS, 15'h40FF);
		write_reg(CFG_UNUSED_A, TICK_MAX);
		write_reg(CFG_UNUSED_B, 15'h5555);
		write_reg(CFG_ONE_HIGH, 15'd1);
		write_reg(CFG_ZERO_LOW, 15'd1);
		push_pixel(24'hFFFFFF, 1'b1);
		push_pixel(24'h0F0F0F, 1'b0);
		push_pixel(24'hF0F0F0, 1'b1);
		settle();

		// smallest non-zero brightness
		write_reg(CFG_BRIGHTNESS, 15'd1);
		push_pixel(24'hFFFFFF, 1'b1);
		push_pixel(24'hFEFEFE, 1'b0);
		push_pixel(24'h01FF80, 1'b1);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			shuffle_regs();
			rx_mode   = ph % 3;
			max_burst = $urandom_range(1, 8);
			max_gap   = (ph == 1) ? 0 : $urandom_range(0, 20);
			if (ph == 2) begin
				// sender keeps offering while the receiver holds off
				rx_mode   = 0;
				max_gap   = 0;
				max_burst = 1000;
				hold_req  = 1'b1;
			end
			burst_left = 0;
			random_phase(62);
		end

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
